// ----- rtl/core/cte_pkg.sv -----
package cte_pkg;

  localparam int unsigned YEAR_FIRST   = 70;   // 1970
  localparam int unsigned YEAR_SPAN    = 68;   // through 2037
  localparam int unsigned MONTH_LAST   = 11;
  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int unsigned DAYS_PER_YR  = 365;

  // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT, exact for x up to 4096
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // after decode
  typedef struct packed {
    logic        date_ok;
    logic [6:0]  year_rel;    // years since 1970
    logic [4:0]  leap_cnt;    // leap days in earlier years
    logic [8:0]  cum_days;
    logic [4:0]  mday;
    logic        leap_adj;
    logic [10:0] hm;          // hour * 60 + minute
    logic [5:0]  sec;
    logic        off_neg;
    logic [12:0] off_mag;
    logic [24:0] off_prod;    // off_mag * DIV100_MUL
  } s1_t;

  typedef struct packed {
    logic        date_ok;
    logic [14:0] days;
    logic [16:0] tod;
    logic        off_neg;
    logic [5:0]  off_hr;
    logic [6:0]  off_mn;
  } s2_t;

  typedef struct packed {
    logic        date_ok;
    logic [30:0] day_sec;
    logic [16:0] tod;
    logic        off_neg;
    logic [17:0] off_sec;
  } s3_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic        date_valid;
  } result_t;

  function automatic logic [8:0] cum_days_f(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/cte_if.sv -----
interface civil_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        years_since_1900;
  logic [3:0]        month_index;
  logic [4:0]        day_of_month;
  logic [4:0]        hour_of_day;
  logic [5:0]        minute_of_hour;
  logic [5:0]        second_of_minute;
  logic signed [12:0] zone_offset_hhmm;

  modport source (
    output valid, years_since_1900, month_index, day_of_month, hour_of_day,
           minute_of_hour, second_of_minute, zone_offset_hhmm,
    input  ready
  );
  modport sink (
    input  valid, years_since_1900, month_index, day_of_month, hour_of_day,
           minute_of_hour, second_of_minute, zone_offset_hhmm,
    output ready
  );
endinterface

interface epoch_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] epoch_seconds;
  logic               date_valid;

  modport source (output valid, epoch_seconds, date_valid, input ready);
  modport sink (input valid, epoch_seconds, date_valid, output ready);
endinterface

// ----- rtl/core/civil_time_to_epoch_seconds.sv -----
// Civil date and time to seconds since 1970-01-01, less a zone offset.
//
// date_in carries one item: year minus 1900, month from 0, day from 1,
// hour, minute, second and a signed HHMM zone offset. epoch_out returns
// one item per input: epoch_seconds and date_valid. A year outside
// 1970..2037, a month above 11 or a day of 0 gives date_valid 0 and
// epoch_seconds 0. Month lengths and time-of-day fields are not checked.
//
// Four register stages (decode, day count, scaling, final sum); an item
// is registered in each stage in turn on its way to epoch_out. One item
// per cycle is taken while epoch_out does not stall.
//
// Each stage holds its item while the next one is full and stalled, so
// a stall at epoch_out backs up stage by stage, and empty stages still
// fill. Nothing is dropped or repeated. Reset clears all stage valid
// bits; the stage data registers are not reset.
module civil_time_to_epoch_seconds
  import cte_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  civil_in_if.sink     date_in,
  epoch_out_if.source  epoch_out
);

  logic    s1_valid, s1_ready;
  logic    s2_valid, s2_ready;
  logic    s3_valid, s3_ready;
  s1_t     s1_data;
  s2_t     s2_data;
  s3_t     s3_data;
  result_t res;

  cte_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (date_in.valid),
    .in_ready  (date_in.ready),
    .yr        (date_in.years_since_1900),
    .mon       (date_in.month_index),
    .mday      (date_in.day_of_month),
    .hr        (date_in.hour_of_day),
    .mi        (date_in.minute_of_hour),
    .se        (date_in.second_of_minute),
    .off       (date_in.zone_offset_hhmm),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  cte_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  cte_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  cte_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (epoch_out.valid),
    .out_ready (epoch_out.ready),
    .out_data  (res)
  );

  assign epoch_out.epoch_seconds = res.epoch_seconds;
  assign epoch_out.date_valid    = res.date_valid;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    epoch_out.valid && !epoch_out.date_valid |-> epoch_out.epoch_seconds == 32'sd0)
    else $error("rejected date with nonzero seconds");

  // widest positive offset field value is 4095, i.e. 2495 minutes
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    epoch_out.valid && epoch_out.date_valid |-> epoch_out.epoch_seconds >= -32'sd149700)
    else $error("epoch seconds below lowest reachable value");

  a_no_throttle: assert property (@(posedge clk) disable iff (rst)
    epoch_out.ready |-> date_in.ready)
    else $error("input held off while output is draining");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !epoch_out.valid && !s1_valid && !s2_valid && !s3_valid)
    else $error("pipeline not empty after reset");

endmodule

// ----- rtl/core/cte_decode.sv -----
module cte_decode
  import cte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  yr,
  input  logic [3:0]  mon,
  input  logic [4:0]  mday,
  input  logic [4:0]  hr,
  input  logic [5:0]  mi,
  input  logic [5:0]  se,
  input  logic [12:0] off,
  output logic        out_valid,
  input  logic        out_ready,
  output s1_t         out_data
);

  s1_t        s1_next;
  logic [7:0] yr_rel;
  logic [7:0] yr_rel_inc;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    yr_rel     = yr - 8'(YEAR_FIRST);
    yr_rel_inc = yr_rel + 8'd1;

    s1_next.date_ok  = (yr >= 8'(YEAR_FIRST)) && (yr < 8'(YEAR_FIRST + YEAR_SPAN)) &&
                       (mon <= 4'(MONTH_LAST)) && (mday != 5'd0);
    s1_next.year_rel = yr_rel[6:0];
    // leap years from 1972 up to the year before; 2000 is the only century
    s1_next.leap_cnt = yr_rel_inc[6:2];
    s1_next.cum_days = cum_days_f(mon);
    s1_next.mday     = mday;
    s1_next.leap_adj = (yr[1:0] == 2'b00) && (mon >= 4'd2);
    s1_next.hm       = 11'(hr) * 11'd60 + 11'(mi);
    s1_next.sec      = se;
    s1_next.off_neg  = off[12];
    s1_next.off_mag  = off[12] ? (13'd0 - off) : off;
    s1_next.off_prod = 25'(s1_next.off_mag) * 25'(DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= s1_next;
    end
  end

endmodule

// ----- rtl/core/cte_days.sv -----
module cte_days
  import cte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_data
);

  s2_t         s2_next;
  logic [5:0]  quot;
  logic [12:0] rem_full;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    quot     = in_data.off_prod[DIV100_SHIFT +: 6];
    rem_full = in_data.off_mag - 13'(quot) * 13'd100;

    s2_next.date_ok = in_data.date_ok;
    s2_next.days    = 15'(in_data.year_rel) * 15'(DAYS_PER_YR) + 15'(in_data.leap_cnt) +
                      15'(in_data.cum_days) + 15'(in_data.mday - 5'd1) +
                      15'(in_data.leap_adj);
    s2_next.tod     = 17'(in_data.hm) * 17'd60 + 17'(in_data.sec);
    s2_next.off_neg = in_data.off_neg;
    s2_next.off_hr  = quot;
    s2_next.off_mn  = rem_full[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= s2_next;
    end
  end

endmodule

// ----- rtl/core/cte_scale.sv -----
module cte_scale
  import cte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s2_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s3_t  out_data
);

  s3_t s3_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    s3_next.date_ok = in_data.date_ok;
    s3_next.day_sec = 31'(in_data.days) * 31'(SEC_PER_DAY);
    s3_next.tod     = in_data.tod;
    s3_next.off_neg = in_data.off_neg;
    // offset minutes part is taken as is, even above 59
    s3_next.off_sec = 18'(in_data.off_hr) * 18'd3600 + 18'(in_data.off_mn) * 18'd60;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= s3_next;
    end
  end

endmodule

// ----- rtl/core/cte_sum.sv -----
module cte_sum
  import cte_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  s3_t     in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t     res_next;
  logic [31:0] base;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    base = 32'(in_data.day_sec) + 32'(in_data.tod);
    // subtract the signed offset: add magnitude for a negative zone
    res_next.date_valid    = in_data.date_ok;
    res_next.epoch_seconds = !in_data.date_ok ? 32'd0 :
                             in_data.off_neg  ? base + 32'(in_data.off_sec) :
                                                base - 32'(in_data.off_sec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule

// ----- test/epoch_result_checker.sv -----
`timescale 1ns / 100ps

module epoch_result_checker
  import cte_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  civil_in_if   date_mon,
  epoch_out_if  epoch_mon,
  output int    fail_count,
  output int    pending
);

  localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int LEAP_BASE_YEAR = 1972;
  localparam int CENTURY_BASE   = 1900;

  result_t expected_epochs [$];
  result_t want;
  int      errs;

  function automatic bit is_leap_year(input int yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic result_t predict_epoch(
    input logic [7:0]         yrs,
    input logic [3:0]         mon,
    input logic [4:0]         mday,
    input logic [4:0]         hr,
    input logic [5:0]         mi,
    input logic [5:0]         se,
    input logic signed [12:0] zone
  );
    result_t r;
    int      full_year;
    longint  days;
    longint  secs;
    longint  mag;
    longint  zone_min;
    r = '0;
    if (yrs < YEAR_FIRST || yrs >= YEAR_FIRST + YEAR_SPAN || mon > MONTH_LAST || mday == 0)
      return r;
    full_year = int'(yrs) + CENTURY_BASE;
    days = 0;
    // leap days of earlier years, century rule included
    for (int y = LEAP_BASE_YEAR; y < full_year; y += 4)
      if (!(y % 100 == 0 && y % 400 != 0)) days++;
    days += longint'(int'(yrs) - int'(YEAR_FIRST)) * DAYS_PER_YR;
    days += MONTH_START[mon] + int'(mday) - 1;
    if (is_leap_year(full_year) && mon >= 2) days++;
    secs = (longint'(hr) * 60 + longint'(mi)) * 60 + longint'(se);
    secs += days * SEC_PER_DAY;
    mag = (zone < 0) ? -longint'(zone) : longint'(zone);
    zone_min = (mag / 100) * 60 + (mag % 100);
    if (zone < 0) zone_min = -zone_min;
    secs -= zone_min * 60;
    r.epoch_seconds = secs[31:0];
    r.date_valid = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_epochs.delete();
      errs = 0;
      pending <= 0;
      fail_count <= 0;
    end else begin
      if (date_mon.valid && date_mon.ready)
        expected_epochs.push_back(predict_epoch(date_mon.years_since_1900,
          date_mon.month_index, date_mon.day_of_month, date_mon.hour_of_day,
          date_mon.minute_of_hour, date_mon.second_of_minute, date_mon.zone_offset_hhmm));
      if (epoch_mon.valid && epoch_mon.ready) begin
        if (expected_epochs.size() == 0) begin
          if (errs < 10)
            $display("%0t: unexpected item: epoch_seconds=%0d date_valid=%0b", $realtime,
                     epoch_mon.epoch_seconds, epoch_mon.date_valid);
          errs++;
        end else begin
          want = expected_epochs.pop_front();
          if (epoch_mon.epoch_seconds !== want.epoch_seconds ||
              epoch_mon.date_valid !== want.date_valid) begin
            if (errs < 10)
              $display("%0t: mismatch: epoch_seconds exp %0d got %0d, date_valid exp %0b got %0b",
                       $realtime, $signed(want.epoch_seconds), epoch_mon.epoch_seconds,
                       want.date_valid, epoch_mon.date_valid);
            errs++;
          end
        end
      end
      pending <= expected_epochs.size();
      fail_count <= errs;
    end
  end

endmodule

// ----- test/tb_civil_time_to_epoch_seconds.sv -----
`timescale 1ns / 100ps

module tb_civil_time_to_epoch_seconds;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 800;

  logic clk;
  logic rst;
  bit   idle_on;
  int   fail_count;
  int   pending;
  int   quiet_cycles;

  civil_in_if  date_ch ();
  epoch_out_if epoch_ch ();

  civil_time_to_epoch_seconds uut (
    .clk       (clk),
    .rst       (rst),
    .date_in   (date_ch),
    .epoch_out (epoch_ch)
  );

  epoch_result_checker chk (
    .clk        (clk),
    .rst        (rst),
    .date_mon   (date_ch),
    .epoch_mon  (epoch_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // called right after an edge; returns at the edge where the item is taken
  task automatic offer_date(
    input logic [7:0]         yrs,
    input logic [3:0]         mon,
    input logic [4:0]         mday,
    input logic [4:0]         hr,
    input logic [5:0]         mi,
    input logic [5:0]         se,
    input logic signed [12:0] zone
  );
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      date_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    date_ch.valid            <= 1'b1;
    date_ch.years_since_1900 <= yrs;
    date_ch.month_index      <= mon;
    date_ch.day_of_month     <= mday;
    date_ch.hour_of_day      <= hr;
    date_ch.minute_of_hour   <= mi;
    date_ch.second_of_minute <= se;
    date_ch.zone_offset_hhmm <= zone;
    @(posedge clk);
    while (!date_ch.ready) @(posedge clk);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain_results();
    date_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic offer_random_date();
    int hh;
    int mm;
    logic signed [12:0] zone;
    if ($urandom_range(0, 99) < 85) begin
      hh = $urandom_range(0, 23);
      mm = $urandom_range(0, 59);
      zone = 13'(hh * 100 + mm);
      if ($urandom_range(0, 1)) zone = -zone;
      offer_date(8'($urandom_range(70, 137)), 4'($urandom_range(0, 11)),
                 5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                 6'($urandom_range(0, 59)), 6'($urandom_range(0, 60)), zone);
    end else begin
      // raw bits: mostly rejected dates, odd times and odd offsets
      offer_date(8'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                 6'($urandom), 6'($urandom), 13'($urandom));
    end
  endtask

  initial begin
    epoch_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        epoch_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      epoch_ch.ready <= 1'b1;
      @(posedge clk);
      while (!epoch_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (date_ch.valid && date_ch.ready) || (epoch_ch.valid && epoch_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst                      <= 1'b1;
    idle_on                  = 1'b1;
    date_ch.valid            <= 1'b0;
    date_ch.years_since_1900 <= '0;
    date_ch.month_index      <= '0;
    date_ch.day_of_month     <= '0;
    date_ch.hour_of_day      <= '0;
    date_ch.minute_of_hour   <= '0;
    date_ch.second_of_minute <= '0;
    date_ch.zone_offset_hhmm <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // epoch itself, then the span extremes with offsets of +2399 and -2399
    offer_date(8'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 13'sd2399);
    offer_date(8'd137, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60, -13'sd2399);
    offer_date(8'd137, 4'd11, 5'd31, 5'd31, 6'd63, 6'd63, 13'sd0);
    // offsets at the limits of the field and with a minute part above 59
    offer_date(8'd100, 4'd5, 5'd15, 5'd12, 6'd30, 6'd30, 13'h1000);
    offer_date(8'd100, 4'd5, 5'd15, 5'd12, 6'd30, 6'd30, 13'h0FFF);
    offer_date(8'd85, 4'd3, 5'd10, 5'd4, 6'd5, 6'd6, 13'sd199);
    offer_date(8'd85, 4'd3, 5'd10, 5'd4, 6'd5, 6'd6, -13'sd99);
    // rejected dates
    offer_date(8'd69, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd138, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 13'h1FFF);
    offer_date(8'd90, 4'd12, 5'd1, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd90, 4'd15, 5'd1, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd90, 4'd4, 5'd0, 5'd0, 6'd0, 6'd0, 13'sd0);
    // leap years: 1972, 2000 (400 rule), 2036; day past month end
    offer_date(8'd72, 4'd1, 5'd29, 5'd23, 6'd59, 6'd59, 13'sd0);
    offer_date(8'd72, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd100, 4'd1, 5'd29, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd100, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0, -13'sd530);
    offer_date(8'd136, 4'd11, 5'd31, 5'd0, 6'd0, 6'd0, 13'sd0);
    offer_date(8'd101, 4'd1, 5'd31, 5'd10, 6'd0, 6'd0, 13'sd100);
    offer_date(8'd99, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60, 13'sd0);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // every third block of 100 runs without idling on either side
      idle_on = ((i / 100) % 3) != 2;
      if (i == RANDOM_ITEMS / 2) drain_results();
      offer_random_date();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cte_pkg.sv
rtl/core/cte_if.sv
rtl/core/cte_decode.sv
rtl/core/cte_days.sv
rtl/core/cte_scale.sv
rtl/core/cte_sum.sv
rtl/core/civil_time_to_epoch_seconds.sv
test/epoch_result_checker.sv
test/tb_civil_time_to_epoch_seconds.sv
